### rtl/core/lbg_pkg.sv
package lbg_pkg;

    // Field widths
    localparam int Z_W      = 20;
    localparam int H_W      = 16;
    localparam int TOP_W    = 21;
    localparam int IDX_W    = 8;
    localparam int SCALE_W  = 17;
    localparam int OBJ_W    = 20;

    // Derived arithmetic widths
    localparam int ZP_W     = Z_W + SCALE_W;    // z * z_scale
    localparam int PB_W     = TOP_W + 2;        // 2*top + height terms
    localparam int PW_W     = PB_W + 15;        // probe in z * z_scale units
    localparam int NUM_W    = PW_W;             // |probe - z1| magnitude
    localparam int DEN_W    = ZP_W;             // |z2 - z1| magnitude
    localparam int HALF_W   = NUM_W / 2;        // multiplier slice of the numerator
    localparam int PROD_W   = H_W + NUM_W;      // product and quotient
    localparam int DCNT_W   = $clog2(PROD_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_HEIGHT    = 3'd0,
        CFG_FIRST_FIXED   = 3'd1,
        CFG_FIRST_HEIGHT  = 3'd2,
        CFG_OBJECT_HEIGHT = 3'd3,
        CFG_Z_SCALE       = 3'd4
    } cfg_idx_t;

    // Register reset values
    localparam logic [H_W-1:0]     RST_MIN_HEIGHT    = 16'd50;
    localparam logic               RST_FIRST_FIXED   = 1'b1;
    localparam logic [H_W-1:0]     RST_FIRST_HEIGHT  = 16'd200;
    localparam logic [OBJ_W-1:0]   RST_OBJECT_HEIGHT = 20'd0;
    localparam logic [SCALE_W-1:0] RST_Z_SCALE       = 17'd65536;

    localparam int DEFAULT_PROFILE_DEPTH = 256;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_FIN,
        OP_FIRST,
        OP_START,
        OP_HEIGHT_MIN,
        OP_RD_NEXT,
        OP_CAP_NEXT,
        OP_ADVANCE,
        OP_KEEP_NEXT,
        OP_RD_SEG,
        OP_CAP_SEG,
        OP_HEIGHT_H1,
        OP_PREP,
        OP_MUL_LO,
        OP_MUL_HI
    } op_t;

    // Further commands
    typedef struct packed {
        op_t  op;
        logic div_step;
        logic sat;
        logic final_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic first_emitted;
        logic first_fixed;
        logic stop_probe;
        logic count_zero;
        logic next_avail;
        logic probe_ge;
        logic flat;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### rtl/core/lbg_item_if.sv
interface lbg_item_if import lbg_pkg::*;;
    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] point_index;
    logic [Z_W-1:0]   point_z;
    logic [H_W-1:0]   point_height;

    modport source (output valid, action, point_index, point_z, point_height, input ready);
    modport sink   (input valid, action, point_index, point_z, point_height, output ready);
endinterface

### rtl/core/lbg_result_if.sv
interface lbg_result_if import lbg_pkg::*;;
    logic             valid;
    logic             ready;
    logic [Z_W-1:0]   layer_bottom;
    logic [TOP_W-1:0] layer_top;
    logic             finished;

    modport source (output valid, layer_bottom, layer_top, finished, input ready);
    modport sink   (input valid, layer_bottom, layer_top, finished, output ready);
endinterface

### rtl/core/lbg_ram.sv
module lbg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/lbg_ctrl.sv
module lbg_ctrl import lbg_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_action,
    output logic    req_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TEST,
        S_ADV_RD,
        S_ADV_CAP,
        S_ADV_CMP,
        S_SEG_RD,
        S_SEG_CAP,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_SAT,
        S_FINAL,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NOP, default: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (!req_action)
                    begin
                        cmd.op = OP_LOAD;
                    end
                    else if (st.done)
                    begin
                        cmd.op     = OP_FIN;
                        state_next = S_EMIT;
                    end
                    else if (!st.first_emitted && st.first_fixed)
                    begin
                        cmd.op     = OP_FIRST;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.op     = OP_START;
                        state_next = S_TEST;
                    end
                end
            end
            S_TEST:
            begin
                if (st.stop_probe)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_EMIT;
                end
                else if (st.count_zero)
                begin
                    cmd.op     = OP_HEIGHT_MIN;
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_ADV_RD;
                end
            end
            S_ADV_RD:
            begin
                if (st.next_avail)
                begin
                    cmd.op     = OP_RD_NEXT;
                    state_next = S_ADV_CAP;
                end
                else
                begin
                    state_next = S_SEG_RD;
                end
            end
            S_ADV_CAP:
            begin
                cmd.op     = OP_CAP_NEXT;
                state_next = S_ADV_CMP;
            end
            S_ADV_CMP:
            begin
                if (st.probe_ge)
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = S_ADV_RD;
                end
                else
                begin
                    cmd.op     = OP_KEEP_NEXT;
                    state_next = S_SEG_RD;
                end
            end
            S_SEG_RD:
            begin
                cmd.op     = OP_RD_SEG;
                state_next = S_SEG_CAP;
            end
            S_SEG_CAP:
            begin
                cmd.op     = OP_CAP_SEG;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.flat)
                begin
                    cmd.op     = OP_HEIGHT_H1;
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.op     = OP_PREP;
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.final_step = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/lbg_dp.sv
module lbg_dp import lbg_pkg::*; #(
    parameter int PROFILE_DEPTH = DEFAULT_PROFILE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               st,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IDX_W-1:0]      point_index,
    input  logic [Z_W-1:0]        point_z,
    input  logic [H_W-1:0]        point_height,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [Z_W-1:0]        out_bottom,
    output logic [TOP_W-1:0]      out_top,
    output logic                  out_finished
);

    localparam int AW = $clog2(PROFILE_DEPTH);
    localparam int CW = $clog2(PROFILE_DEPTH + 1);

    // Configuration registers
    logic [H_W-1:0]     min_height_reg;
    logic               first_fixed_reg;
    logic [H_W-1:0]     first_height_reg;
    logic [OBJ_W-1:0]   object_height_reg;
    logic [SCALE_W-1:0] z_scale_reg;

    // Generation state
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      seg_reg;
    logic [CW-1:0]      next_reg;
    logic [TOP_W-1:0]   top_reg;
    logic               first_reg;
    logic               done_reg;
    logic               has_next_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               out_valid_reg;

    // Working values
    logic [ZP_W-1:0]    z1p_reg, z2p_reg;
    logic [H_W-1:0]     h1_reg, h2_reg;
    logic [NUM_W-1:0]   nmag_reg;
    logic [DEN_W-1:0]   dmag_reg;
    logic [H_W-1:0]     hmag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [H_W-1:0]     height_reg;
    logic [Z_W-1:0]     res_bottom_reg, out_bottom_reg;
    logic [TOP_W-1:0]   res_top_reg, out_top_reg;
    logic               res_fin_reg, out_fin_reg;

    // Profile memories
    logic               idx_ok;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [Z_W-1:0]     ram_z;
    logic [H_W-1:0]     ram_h;

    assign idx_ok = (int'(point_index) < PROFILE_DEPTH);
    assign ram_we = (cmd.op == OP_LOAD) && idx_ok;

    always_comb
    begin
        unique case (cmd.op)
            OP_RD_NEXT: ram_addr = next_reg[AW-1:0];
            OP_RD_SEG:  ram_addr = seg_reg;
            default:    ram_addr = AW'(point_index);
        endcase
    end

    lbg_ram #(.WIDTH(Z_W), .DEPTH(PROFILE_DEPTH)) u_zram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(point_z), .rdata(ram_z)
    );

    lbg_ram #(.WIDTH(H_W), .DEPTH(PROFILE_DEPTH)) u_hram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(point_height), .rdata(ram_h)
    );

    // Scaled z of the word just read
    logic [ZP_W-1:0]    zp;
    assign zp = ZP_W'(ram_z) * ZP_W'(z_scale_reg);

    // Probe: 2*top + min_height, and the same in z * z_scale units
    logic [PB_W-1:0]    pb;
    logic [PB_W-1:0]    obj2;
    logic [PW_W-1:0]    pw;
    assign pb   = PB_W'({top_reg, 1'b0}) + PB_W'(min_height_reg);
    assign obj2 = PB_W'({object_height_reg, 1'b0});
    assign pw   = {pb, 15'b0};

    // Interpolation operands
    logic signed [NUM_W:0]  numd;
    logic signed [DEN_W:0]  dend;
    logic signed [H_W:0]    hd;
    assign numd = $signed({1'b0, pw}) - $signed({1'b0, NUM_W'(z1p_reg)});
    assign dend = $signed({1'b0, z2p_reg}) - $signed({1'b0, z1p_reg});
    assign hd   = $signed({1'b0, h2_reg}) - $signed({1'b0, h1_reg});

    // Shared partial-product multiplier
    logic [H_W+HALF_W-1:0]  mpart;
    assign mpart = (H_W + HALF_W)'(hmag_reg) *
                   (H_W + HALF_W)'((cmd.op == OP_MUL_HI) ? nmag_reg[NUM_W-1:HALF_W]
                                                        : nmag_reg[HALF_W-1:0]);

    // Restoring division step
    logic [DEN_W:0]     trial;
    logic               q_bit;
    logic [DEN_W:0]     diff;
    assign trial = {rem_reg, prod_reg[PROD_W-1]};
    assign q_bit = (trial >= {1'b0, dmag_reg});
    assign diff  = trial - {1'b0, dmag_reg};

    // Saturating height from the quotient
    logic               q_big;
    logic [H_W:0]       q_sum;
    logic [H_W-1:0]     sat_height;
    assign q_big = |prod_reg[PROD_W-1:H_W];
    assign q_sum = {1'b0, h1_reg} + {1'b0, prod_reg[H_W-1:0]};
    always_comb
    begin
        if (neg_reg)
        begin
            sat_height = (q_big || (prod_reg[H_W-1:0] > h1_reg)) ? '0
                                                                 : h1_reg - prod_reg[H_W-1:0];
        end
        else
        begin
            sat_height = (q_big || q_sum[H_W]) ? '1 : q_sum[H_W-1:0];
        end
    end

    // Stop test on the finished height, and the next top
    logic               stop_height;
    logic [TOP_W-1:0]   new_top;
    assign stop_height = (PB_W'({top_reg, 1'b0}) + PB_W'(height_reg)) >= obj2;
    assign new_top     = top_reg + TOP_W'(height_reg);

    // Status to the controller
    always_comb
    begin
        st.done          = done_reg;
        st.first_emitted = first_reg;
        st.first_fixed   = first_fixed_reg;
        st.stop_probe    = (pb >= obj2);
        st.count_zero    = (count_reg == '0);
        st.next_avail    = (next_reg < count_reg);
        st.probe_ge      = (pw >= PW_W'(z2p_reg));
        st.flat          = !has_next_reg || (z2p_reg == z1p_reg);
        st.div_last      = (dcnt_reg == DCNT_W'(PROD_W - 1));
        st.out_free      = !out_valid_reg || out_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_height_reg    <= RST_MIN_HEIGHT;
            first_fixed_reg   <= RST_FIRST_FIXED;
            first_height_reg  <= RST_FIRST_HEIGHT;
            object_height_reg <= RST_OBJECT_HEIGHT;
            z_scale_reg       <= RST_Z_SCALE;
            count_reg         <= '0;
            seg_reg           <= '0;
            next_reg          <= '0;
            top_reg           <= '0;
            first_reg         <= 1'b0;
            done_reg          <= 1'b0;
            has_next_reg      <= 1'b0;
            dcnt_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MIN_HEIGHT:    min_height_reg    <= cfg_data[H_W-1:0];
                    CFG_FIRST_FIXED:   first_fixed_reg   <= cfg_data[0];
                    CFG_FIRST_HEIGHT:  first_height_reg  <= cfg_data[H_W-1:0];
                    CFG_OBJECT_HEIGHT: object_height_reg <= cfg_data[OBJ_W-1:0];
                    CFG_Z_SCALE:       z_scale_reg       <= cfg_data[SCALE_W-1:0];
                    default:           ;
                endcase
            end

            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (idx_ok)
                    begin
                        count_reg <= CW'(point_index) + CW'(1);
                        seg_reg   <= '0;
                        top_reg   <= '0;
                        first_reg <= 1'b0;
                        done_reg  <= 1'b0;
                    end
                end
                OP_FIN:
                begin
                    done_reg <= 1'b1;
                end
                OP_FIRST:
                begin
                    first_reg <= 1'b1;
                    top_reg   <= TOP_W'(first_height_reg);
                end
                OP_START:
                begin
                    first_reg    <= 1'b1;
                    next_reg     <= CW'(seg_reg) + CW'(1);
                    has_next_reg <= 1'b0;
                end
                OP_ADVANCE:
                begin
                    seg_reg  <= next_reg[AW-1:0];
                    next_reg <= next_reg + CW'(1);
                end
                OP_KEEP_NEXT:
                begin
                    has_next_reg <= 1'b1;
                end
                OP_MUL_HI:
                begin
                    dcnt_reg <= '0;
                end
                default:
                begin
                end
            endcase

            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end

            if (cmd.final_step)
            begin
                if (stop_height)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    top_reg <= new_top;
                end
            end

            // Output register
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_FIN:
            begin
                res_bottom_reg <= '0;
                res_top_reg    <= '0;
                res_fin_reg    <= 1'b1;
            end
            OP_FIRST:
            begin
                res_bottom_reg <= '0;
                res_top_reg    <= TOP_W'(first_height_reg);
                res_fin_reg    <= 1'b0;
            end
            OP_HEIGHT_MIN:
            begin
                height_reg <= min_height_reg;
            end
            OP_CAP_NEXT:
            begin
                z2p_reg <= zp;
                h2_reg  <= ram_h;
            end
            OP_CAP_SEG:
            begin
                z1p_reg <= zp;
                h1_reg  <= ram_h;
            end
            OP_HEIGHT_H1:
            begin
                height_reg <= h1_reg;
            end
            OP_PREP:
            begin
                nmag_reg <= numd[NUM_W] ? NUM_W'(-numd) : numd[NUM_W-1:0];
                dmag_reg <= dend[DEN_W] ? DEN_W'(-dend) : dend[DEN_W-1:0];
                hmag_reg <= hd[H_W] ? H_W'(-hd) : hd[H_W-1:0];
                neg_reg  <= numd[NUM_W] ^ dend[DEN_W] ^ hd[H_W];
            end
            OP_MUL_LO:
            begin
                prod_reg <= PROD_W'(mpart);
            end
            OP_MUL_HI:
            begin
                prod_reg <= prod_reg + PROD_W'({mpart, HALF_W'(0)});
                rem_reg  <= '0;
            end
            default:
            begin
            end
        endcase

        if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            prod_reg <= {prod_reg[PROD_W-2:0], q_bit};
        end

        if (cmd.sat)
        begin
            height_reg <= sat_height;
        end

        if (cmd.final_step)
        begin
            res_bottom_reg <= stop_height ? '0 : top_reg[Z_W-1:0];
            res_top_reg    <= stop_height ? '0 : new_top;
            res_fin_reg    <= stop_height;
        end

        if (cmd.emit)
        begin
            out_bottom_reg <= res_bottom_reg;
            out_top_reg    <= res_top_reg;
            out_fin_reg    <= res_fin_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_bottom   = out_bottom_reg;
    assign out_top      = out_top_reg;
    assign out_finished = out_fin_reg;

endmodule

### rtl/core/layer_boundary_generator.sv
// channel  | dir | words
// request  | in  | action, point_index, point_z, point_height
// result   | out | layer_bottom, layer_top, finished (one per layer request)
// config   | in  | cfg_we, cfg_index, cfg_data
//
// From acceptance to the output register: a load only writes the profile; a fixed first
// layer or finished word goes straight out; else the probe test may finish the run, an
// empty profile takes min_height, or the walk checks following points against the probe,
// reads the segment and interpolates unless flat, dividing bit-serially (54 quotient bits).
// One word at a time; the result waits in the output register, and the next one stalls
// until it is taken. Reset is asynchronous, active low; profile contents stay undefined.
module layer_boundary_generator import lbg_pkg::*; #(
    parameter int PROFILE_DEPTH = DEFAULT_PROFILE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lbg_item_if.sink              request,
    lbg_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    lbg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_action (request.action),
        .req_ready  (request.ready),
        .st         (st),
        .cmd        (cmd)
    );

    lbg_dp #(.PROFILE_DEPTH(PROFILE_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_index  (request.point_index),
        .point_z      (request.point_z),
        .point_height (request.point_height),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_bottom   (result.layer_bottom),
        .out_top      (result.layer_top),
        .out_finished (result.finished)
    );

endmodule

### rtl/core/lbg_checker.sv
module lbg_checker import lbg_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_action,
    input logic             res_valid,
    input logic             res_ready,
    input logic [Z_W-1:0]   res_bottom,
    input logic [TOP_W-1:0] res_top,
    input logic             res_finished
);

    // Stalled result word stays valid and holds its bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_top) && $stable(res_bottom))
    else $error("stalled result word changed");

    // Finished mark carries zero bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_finished |-> res_bottom == '0 && res_top == '0)
    else $error("finished word with nonzero bounds");

    // Layers never run downwards
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_finished |-> res_top >= TOP_W'(res_bottom))
    else $error("layer top below bottom");

    // A load produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid && req_valid && req_ready && !req_action |=> !res_valid)
    else $error("result word after a load");

endmodule

bind layer_boundary_generator lbg_checker u_lbg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .req_action   (request.action),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_bottom   (result.layer_bottom),
    .res_top      (result.layer_top),
    .res_finished (result.finished)
);

### tb/tb_top.sv
module tb_top;
    import lbg_pkg::*;

    typedef struct {
        bit [Z_W-1:0]   bottom;
        bit [TOP_W-1:0] top;
        bit             fin;
    } layer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lbg_item_if   req_if ();
    lbg_result_if res_if ();

    layer_boundary_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Expected layers, oldest first
    layer_t layers_due[$];
    int     fail_count = 0;
    int     words_sent;
    bit     quiet;
    int     hold_len = 0;
    int     hold_asks = 0;

    // Predictor state and its copy of the registers
    bit [Z_W-1:0]     prof_z[256];
    bit [H_W-1:0]     prof_h[256];
    int               prof_count;
    int               prof_filled;
    int               seg_idx;
    bit [TOP_W-1:0]   cur_top;
    bit               first_done;
    bit               gen_done;
    bit [H_W-1:0]     c_min;
    bit               c_first_fixed;
    bit [H_W-1:0]     c_first_height;
    bit [OBJ_W-1:0]   c_object;
    bit [SCALE_W-1:0] c_scale;

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus a long hold when a test asks for one
    always @(negedge clk)
    begin : ready_gen
        static int stall_left = 0;
        static int hold_seen = 0;
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            stall_left = hold_len;
        end
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 9) < 3)
        begin
            stall_left = pick_gap();
            res_if.ready <= (stall_left == 0);
        end
        else
            res_if.ready <= 1'b1;
    end

    // Compare every accepted layer word with the oldest expectation
    always @(posedge clk)
    begin
        layer_t exp_l;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (layers_due.size() == 0)
            begin
                $display("%0t: unexpected word bottom=%0d top=%0d fin=%0b", $time,
                         res_if.layer_bottom, res_if.layer_top, res_if.finished);
                fail_count++;
            end
            else
            begin
                exp_l = layers_due.pop_front();
                if (res_if.layer_bottom !== exp_l.bottom)
                begin
                    $display("%0t: layer_bottom expected %0d got %0d", $time,
                             exp_l.bottom, res_if.layer_bottom);
                    fail_count++;
                end
                if (res_if.layer_top !== exp_l.top)
                begin
                    $display("%0t: layer_top expected %0d got %0d", $time,
                             exp_l.top, res_if.layer_top);
                    fail_count++;
                end
                if (res_if.finished !== exp_l.fin)
                begin
                    $display("%0t: finished expected %0b got %0b", $time,
                             exp_l.fin, res_if.finished);
                    fail_count++;
                end
            end
        end
    end

    function automatic longint scaled_z(int i);
        return 2 * longint'(prof_z[i]) * longint'(c_scale);
    endfunction

    // Queue one expected layer at the back
    function automatic void expect_layer(layer_t l);
        layers_due.insert(layers_due.size(), l);
    endfunction

    // Work out the layer (if any) that one accepted word produces
    function automatic void predict_layer(bit act, bit [IDX_W-1:0] idx,
                                          bit [Z_W-1:0] z, bit [H_W-1:0] h);
        layer_t l;
        longint hgt, probe, obj2, z1, z2, h1, h2, base;
        int nxt;
        l.bottom = '0;
        l.top = '0;
        l.fin = 1'b1;
        if (!act)
        begin
            prof_z[idx] = z;
            prof_h[idx] = h;
            prof_count = idx + 1;
            if (idx == prof_filled && prof_filled < 256)
                prof_filled++;
            seg_idx = 0;
            cur_top = '0;
            first_done = 0;
            gen_done = 0;
            return;
        end
        if (gen_done)
        begin
            expect_layer(l);
            return;
        end
        if (!first_done)
        begin
            first_done = 1;
            if (c_first_fixed)
            begin
                cur_top = TOP_W'(c_first_height);
                l.top = TOP_W'(c_first_height);
                l.fin = 1'b0;
                expect_layer(l);
                return;
            end
        end
        obj2 = 2 * longint'(c_object);
        base = 2 * longint'(cur_top) + longint'(c_min);
        if (base >= obj2)
        begin
            gen_done = 1;
            expect_layer(l);
            return;
        end
        probe = base * 65536;
        hgt = longint'(c_min);
        if (prof_count > 0 && seg_idx < prof_count)
        begin
            nxt = seg_idx + 1;
            while (nxt < prof_count && probe >= scaled_z(nxt))
            begin
                seg_idx = nxt;
                nxt++;
            end
            z1 = scaled_z(seg_idx);
            h1 = longint'(prof_h[seg_idx]);
            hgt = h1;
            if (nxt < prof_count)
            begin
                z2 = scaled_z(nxt);
                h2 = longint'(prof_h[nxt]);
                if (z2 != z1)
                    hgt = h1 + ((h2 - h1) * (probe - z1)) / (z2 - z1);
            end
        end
        if (hgt < 0)
            hgt = 0;
        if (hgt > 65535)
            hgt = 65535;
        if (2 * longint'(cur_top) + hgt >= obj2)
        begin
            gen_done = 1;
            expect_layer(l);
            return;
        end
        l.bottom = cur_top[Z_W-1:0];
        cur_top = cur_top + hgt[TOP_W-1:0];
        l.top = cur_top;
        l.fin = 1'b0;
        expect_layer(l);
    endfunction

    // Offer one word and wait until it is taken; valid stays up afterwards
    task automatic send_word(bit act, bit [IDX_W-1:0] idx, bit [Z_W-1:0] z,
                             bit [H_W-1:0] h);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.action = act;
        req_if.point_index = idx;
        req_if.point_z = z;
        req_if.point_height = h;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_layer(act, idx, z, h);
        words_sent++;
    endtask

    task automatic load_point(int idx, bit [Z_W-1:0] z, bit [H_W-1:0] h);
        send_word(1'b0, idx[IDX_W-1:0], z, h);
    endtask

    task automatic ask_layer();
        send_word(1'b1, IDX_W'($urandom), Z_W'($urandom), H_W'($urandom));
    endtask

    // Drain everything and let the block fall idle
    task automatic settle();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (layers_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, bit [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MIN_HEIGHT:    c_min = val[H_W-1:0];
            CFG_FIRST_FIXED:   c_first_fixed = val[0];
            CFG_FIRST_HEIGHT:  c_first_height = val[H_W-1:0];
            CFG_OBJECT_HEIGHT: c_object = val[OBJ_W-1:0];
            CFG_Z_SCALE:       c_scale = val[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(int mh, int ff, int fh, int obj, int zs);
        cfg_write(CFG_MIN_HEIGHT, CFG_DATA_W'(mh));
        cfg_write(CFG_FIRST_FIXED, CFG_DATA_W'(ff));
        cfg_write(CFG_FIRST_HEIGHT, CFG_DATA_W'(fh));
        cfg_write(CFG_OBJECT_HEIGHT, CFG_DATA_W'(obj));
        cfg_write(CFG_Z_SCALE, CFG_DATA_W'(zs));
    endtask

    // Requests until the generation reports finished, plus a couple more
    task automatic run_layers(int max_req);
        int n;
        n = 0;
        while (!gen_done && n < max_req)
        begin
            ask_layer();
            n++;
        end
        repeat ($urandom_range(1, 2)) ask_layer();
    endtask

    // Reset values: fixed first layer, then finished at object height zero
    task automatic test_reset_defaults();
        ask_layer();
        ask_layer();
        ask_layer();
        settle();
    endtask

    // No profile loaded yet: every layer is min_height thick
    task automatic test_empty_profile();
        set_all(120, 0, 200, 1000, 65536);
        run_layers(20);
        settle();
    endtask

    // Field and register extremes, zero-length segments, extrapolation
    task automatic test_extremes();
        set_all(1, 1, 0, 1048575, 0);
        load_point(0, 20'hFFFFF, 16'hFFFF);
        load_point(1, 0, 0);
        repeat (4) ask_layer();
        settle();
        set_all(65535, 1, 65535, 1048575, 131071);
        load_point(0, 500, 100);
        load_point(1, 500, 300);
        load_point(2, 20'h7FFFF, 16'h8000);
        repeat (5) ask_layer();
        settle();
        set_all(100, 0, 0, 3000, 65536);
        load_point(0, 1000, 65535);
        load_point(1, 2000, 0);
        repeat (4) ask_layer();
        load_point(0, 1000, 0);
        repeat (3) ask_layer();
        settle();
    endtask

    // Fill every profile entry so that the top index is reached
    task automatic test_full_profile();
        set_all(40, 1, 150, 60000, 65536);
        for (int i = 0; i < 256; i++)
            load_point(i, Z_W'(i * 200), H_W'($urandom_range(50, 300)));
        run_layers(400);
        settle();
    endtask

    // Result side held off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_all(60, 1, 100, 100000, 65536);
        load_point(0, 0, 80);
        load_point(1, 5000, 200);
        hold_len = 400;
        hold_asks++;
        repeat (30) ask_layer();
        settle();
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(0, 9);
        cfg_write(CFG_MIN_HEIGHT,
                  CFG_DATA_W'(r == 0 ? 1 : r == 1 ? 65535 : $urandom_range(20, 300)));
        cfg_write(CFG_FIRST_FIXED, CFG_DATA_W'($urandom_range(0, 1)));
        r = $urandom_range(0, 9);
        cfg_write(CFG_FIRST_HEIGHT,
                  CFG_DATA_W'(r == 0 ? 0 : r == 1 ? 65535 : $urandom_range(50, 500)));
        r = $urandom_range(0, 19);
        cfg_write(CFG_OBJECT_HEIGHT, CFG_DATA_W'(r == 0 ? 0 : r == 1 ? 1048575 :
                  $urandom_range(500, 8000)));
        r = $urandom_range(0, 9);
        cfg_write(CFG_Z_SCALE,
                  CFG_DATA_W'(r == 0 ? 0 : r == 1 ? 131071 : $urandom_range(50000, 80000)));
    endtask

    // Mostly well-formed profiles followed by layer runs, some noise
    task automatic test_random();
        int n, zc, lim;
        while (words_sent < 1200)
        begin
            settle();
            quiet = ($urandom_range(0, 4) == 0);
            random_config();
            n = $urandom_range(1, 8);
            zc = $urandom_range(0, 500);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_point(i, Z_W'($urandom), H_W'($urandom));
                else
                    load_point(i, Z_W'(zc), H_W'($urandom_range(0, 9) == 0 ? $urandom :
                               $urandom_range(0, 400)));
                zc += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2000);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                // broken sequence: loads mixed into the layer run
                repeat ($urandom_range(2, 10))
                begin
                    lim = prof_filled > 255 ? 255 : prof_filled;
                    if ($urandom_range(0, 2) == 0)
                        load_point($urandom_range(0, lim), Z_W'($urandom), H_W'($urandom));
                    else
                        ask_layer();
                end
            end
            run_layers(80);
        end
        quiet = 0;
        settle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.action = 1'b0;
        req_if.point_index = '0;
        req_if.point_z = '0;
        req_if.point_height = '0;
        words_sent = 0;
        quiet = 0;
        prof_count = 0;
        prof_filled = 0;
        seg_idx = 0;
        cur_top = '0;
        first_done = 0;
        gen_done = 0;
        c_min = RST_MIN_HEIGHT;
        c_first_fixed = RST_FIRST_FIXED;
        c_first_height = RST_FIRST_HEIGHT;
        c_object = RST_OBJECT_HEIGHT;
        c_scale = RST_Z_SCALE;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(posedge clk);

        test_reset_defaults();
        test_empty_profile();
        test_extremes();
        test_backpressure();
        test_full_profile();
        test_random();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
